// ===== sv/dwsrl_pkg.sv =====
// ----------------------------------------------------------------------------
// Dual-window send rate limiter package
// Widths, register indexes, status codes and reset values that are shared by
// the limiter's files.
// ----------------------------------------------------------------------------
package dwsrl_pkg;

  localparam int LOG_DEPTH   = 8;
  localparam int TIME_W      = 32;
  localparam int INTERVAL_W  = 8;
  localparam int WINDOW_W    = 16;
  localparam int LIMIT_W     = 4;
  localparam int STATUS_W    = 3;
  localparam int COUNT_OUT_W = 4;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  typedef logic [TIME_W-1:0] time_t;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_INTERVAL = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_WINDOW  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_LIMIT   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SHORT_WINDOW = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SHORT_LIMIT  = 3'd4;

  // Register reset values
  localparam logic [INTERVAL_W-1:0] MIN_INTERVAL_RESET = 8'd1;
  localparam logic [WINDOW_W-1:0]   LONG_WINDOW_RESET  = 16'd15;
  localparam logic [LIMIT_W-1:0]    LONG_LIMIT_RESET   = 4'd5;
  localparam logic [WINDOW_W-1:0]   SHORT_WINDOW_RESET = 16'd5;
  localparam logic [LIMIT_W-1:0]    SHORT_LIMIT_RESET  = 4'd3;

  // Commands
  localparam logic CMD_QUEUE = 1'b0;
  localparam logic CMD_TRY   = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_SENT       = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_PENDING = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_TOO_SOON   = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_LONG_FULL  = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_SHORT_FULL = 3'd4;
  localparam logic [STATUS_W-1:0] STATUS_QUEUED     = 3'd5;

  // Per-cell control: shift takes the neighbor's entry, load takes the time
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

// ===== sv/dwsrl_cmd_if.sv =====
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel that carries one queue or try command and its time.
// ----------------------------------------------------------------------------
interface dwsrl_cmd_if;
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic [dwsrl_pkg::TIME_W-1:0] now_sec;

  modport source (output valid, output command, output now_sec, input ready);
  modport sink   (input valid, input command, input now_sec, output ready);
endinterface

// ===== sv/dwsrl_result_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries the outcome of one command.
// ----------------------------------------------------------------------------
interface dwsrl_result_if;
  logic                              valid;
  logic                              ready;
  logic                              send_granted;
  logic [dwsrl_pkg::STATUS_W-1:0]    status;
  logic [dwsrl_pkg::COUNT_OUT_W-1:0] window_count;

  modport source (output valid, output send_granted, output status, output window_count,
                  input ready);
  modport sink   (input valid, input send_granted, input status, input window_count,
                  output ready);
endinterface

// ===== sv/dwsrl_cell.sv =====
// ----------------------------------------------------------------------------
// Send time log cell
// Holds one logged send time; takes its neighbor's entry on a shift or the
// current time on a load.
// ----------------------------------------------------------------------------
module dwsrl_cell (
  input  logic                 clk,
  input  dwsrl_pkg::cell_ctl_t ctl,
  input  dwsrl_pkg::time_t     neighbor,
  input  dwsrl_pkg::time_t     now,
  output dwsrl_pkg::time_t     entry
);

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      entry <= neighbor;
    end else if (ctl.load) begin
      entry <= now;
    end
  end

endmodule

// ===== sv/dual_window_send_rate_limiter_core.sv =====
// ----------------------------------------------------------------------------
// Dual-window send rate limiter
// Single-slot send gate with a sliding-window log of granted send times.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries a command (queue or try) and the current time in seconds;
//   result returns one item per command: send_granted, status and the number
//   of logged send times. The user must write registers through cfg_write/
//   cfg_index/cfg_data only while the block is idle; the block does not enforce it.
// Sequence: a queue, nothing-pending or too-soon command passes from the
//   evaluate state to the finish state, which loads the output register. A
//   try that reaches the windows prunes stale entries (one per cycle at the
//   head of the cell row), then rotates the row past the head to count the
//   short window, then decides and finishes. One command is in work at a
//   time; the next is taken the cycle after the result is loaded.
// Reset: the pending mark, log count and last send time clear and the
//   registers take their defaults; log cells are not cleared, the count
//   marks which are valid.
// Stall: the finished result holds in the output register while result.ready
//   is low; a following command may be taken and is held at its end until
//   the output register frees.
// ----------------------------------------------------------------------------
module dual_window_send_rate_limiter_core #(
  parameter int LOG_DEPTH = dwsrl_pkg::LOG_DEPTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  dwsrl_cmd_if.sink                             cmd,
  dwsrl_result_if.source                        result,
  input  logic                                  cfg_write,
  input  logic [dwsrl_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [dwsrl_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int CW = $clog2(LOG_DEPTH + 1);
  localparam int SW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int DW = ((CW > dwsrl_pkg::LIMIT_W) ? CW : dwsrl_pkg::LIMIT_W) + 1;
  localparam int TW = dwsrl_pkg::TIME_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EVAL   = 3'd1;
  localparam logic [2:0] ST_PRUNE  = 3'd2;
  localparam logic [2:0] ST_COUNT  = 3'd3;
  localparam logic [2:0] ST_DECIDE = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  // Configuration registers
  logic [dwsrl_pkg::INTERVAL_W-1:0] min_interval;
  logic [dwsrl_pkg::WINDOW_W-1:0]   long_window;
  logic [dwsrl_pkg::LIMIT_W-1:0]    long_limit;
  logic [dwsrl_pkg::WINDOW_W-1:0]   short_window;
  logic [dwsrl_pkg::LIMIT_W-1:0]    short_limit;

  logic [2:0]                     state;
  logic                           cmd_q;
  dwsrl_pkg::time_t               now_q;
  dwsrl_pkg::time_t               lstart;
  dwsrl_pkg::time_t               sstart;
  logic [CW-1:0]                  count;
  logic [CW-1:0]                  shortn;
  logic [SW-1:0]                  step;
  logic                           pending;
  dwsrl_pkg::time_t               last_send;
  logic                           res_granted;
  logic [dwsrl_pkg::STATUS_W-1:0] res_status;
  logic                           out_valid;
  logic                           out_granted;
  logic [dwsrl_pkg::STATUS_W-1:0] out_status;
  logic [dwsrl_pkg::COUNT_OUT_W-1:0] out_count;

  dwsrl_pkg::time_t     entries [LOG_DEPTH];
  dwsrl_pkg::time_t     neighbor [LOG_DEPTH];
  dwsrl_pkg::cell_ctl_t cell_ctl [LOG_DEPTH];
  dwsrl_pkg::time_t     tail_in;

  logic [TW:0]  since_last;
  logic         too_soon;
  logic         prune_drop;
  logic         short_hit;
  logic         log_full;
  logic         long_full;
  logic         short_full;
  logic         grant_ok;
  logic         chain_shift;
  logic         chain_load;
  logic         out_free;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      min_interval <= dwsrl_pkg::MIN_INTERVAL_RESET;
      long_window  <= dwsrl_pkg::LONG_WINDOW_RESET;
      long_limit   <= dwsrl_pkg::LONG_LIMIT_RESET;
      short_window <= dwsrl_pkg::SHORT_WINDOW_RESET;
      short_limit  <= dwsrl_pkg::SHORT_LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        dwsrl_pkg::REG_MIN_INTERVAL: min_interval <= cfg_data[dwsrl_pkg::INTERVAL_W-1:0];
        dwsrl_pkg::REG_LONG_WINDOW:  long_window  <= cfg_data[dwsrl_pkg::WINDOW_W-1:0];
        dwsrl_pkg::REG_LONG_LIMIT:   long_limit   <= cfg_data[dwsrl_pkg::LIMIT_W-1:0];
        dwsrl_pkg::REG_SHORT_WINDOW: short_window <= cfg_data[dwsrl_pkg::WINDOW_W-1:0];
        dwsrl_pkg::REG_SHORT_LIMIT:  short_limit  <= cfg_data[dwsrl_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- decision logic
  assign since_last = {1'b0, now_q} - {1'b0, last_send};
  assign too_soon   = since_last[TW] || (since_last[TW-1:0] < TW'(min_interval));

  assign prune_drop = (count != '0) && (entries[0] < lstart);
  assign short_hit  = (CW'(step) < count) && (entries[0] >= sstart);
  assign log_full   = (count == CW'(LOG_DEPTH));
  assign long_full  = (DW'(count) + DW'(1)) >= DW'(long_limit);
  assign short_full = (DW'(shortn) + DW'(1)) >= DW'(short_limit);
  assign grant_ok   = (state == ST_DECIDE) && !long_full && !short_full;

  // Shift out stale entries while pruning, rotate during the count pass; on a
  // grant into a full log the new time enters at the tail, the oldest falls off the head.
  assign chain_shift = ((state == ST_PRUNE) && prune_drop) || (state == ST_COUNT) ||
                       (grant_ok && log_full);
  assign chain_load  = grant_ok && !log_full;
  assign tail_in     = (state == ST_COUNT) ? entries[0] : now_q;

  // -------------------------------------------------------------- cell row
  for (genvar i = 0; i < LOG_DEPTH; i++) begin : g_cell
    if (i == LOG_DEPTH - 1) begin : g_tail
      assign neighbor[i] = tail_in;
    end else begin : g_body
      assign neighbor[i] = entries[i+1];
    end
    assign cell_ctl[i].shift = chain_shift;
    assign cell_ctl[i].load  = chain_load && (count == CW'(i));

    dwsrl_cell u_cell (
      .clk      (clk),
      .ctl      (cell_ctl[i]),
      .neighbor (neighbor[i]),
      .now      (now_q),
      .entry    (entries[i])
    );
  end

  // ---------------------------------------------------------- sequencer
  assign cmd.ready = (state == ST_IDLE);
  assign out_free  = !out_valid || result.ready;

  // Load a finished result, or drop the held one once it transfers
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_FINISH) && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      pending   <= 1'b0;
      last_send <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd.valid) begin
            cmd_q <= cmd.command;
            now_q <= cmd.now_sec;
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          lstart <= (now_q > TW'(long_window)) ? now_q - TW'(long_window) : '0;
          sstart <= (now_q > TW'(short_window)) ? now_q - TW'(short_window) : '0;
          res_granted <= 1'b0;
          if (cmd_q == dwsrl_pkg::CMD_QUEUE) begin
            pending    <= 1'b1;
            res_status <= dwsrl_pkg::STATUS_QUEUED;
            state      <= ST_FINISH;
          end else if (!pending) begin
            res_status <= dwsrl_pkg::STATUS_NO_PENDING;
            state      <= ST_FINISH;
          end else if (too_soon) begin
            res_status <= dwsrl_pkg::STATUS_TOO_SOON;
            state      <= ST_FINISH;
          end else begin
            state <= ST_PRUNE;
          end
        end
        ST_PRUNE: begin
          // drop stale entries off the head, one per cycle
          if (prune_drop) begin
            count <= count - CW'(1);
          end else begin
            step   <= '0;
            shortn <= '0;
            state  <= ST_COUNT;
          end
        end
        ST_COUNT: begin
          if (short_hit) begin
            shortn <= shortn + CW'(1);
          end
          step <= step + SW'(1);
          if (step == SW'(LOG_DEPTH - 1)) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (long_full) begin
            res_status <= dwsrl_pkg::STATUS_LONG_FULL;
          end else if (short_full) begin
            res_status <= dwsrl_pkg::STATUS_SHORT_FULL;
          end else begin
            res_status  <= dwsrl_pkg::STATUS_SENT;
            res_granted <= 1'b1;
            pending     <= 1'b0;
            last_send   <= now_q;
            if (!log_full) begin
              count <= count + CW'(1);
            end
          end
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          // hold until the output register frees
          if (out_free) begin
            out_granted <= res_granted;
            out_status  <= res_status;
            out_count   <= dwsrl_pkg::COUNT_OUT_W'(count);
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign result.valid        = out_valid;
  assign result.send_granted = out_granted;
  assign result.status       = out_status;
  assign result.window_count = out_count;

  // ------------------------------------------------------------ assertions
`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(LOG_DEPTH))
    else $error("log count beyond log depth");

  a_grant_clears_pending: assert property (@(posedge clk) disable iff (rst)
    grant_ok |=> !pending)
    else $error("pending mark survived a grant");

  a_grant_time_order: assert property (@(posedge clk) disable iff (rst)
    grant_ok |-> (now_q >= last_send))
    else $error("grant logged a time older than the last send");

  a_result_grant_code: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.send_granted == (result.status == dwsrl_pkg::STATUS_SENT)))
    else $error("grant flag and status disagree");
`endif

endmodule
